// ===== src/tvlg_pkg.sv =====
// ----------------------------------------------------------------------------
// tvlg_pkg
// Shared types, constants and saturation helpers for the tv/l2 loss gradient
// block.
// ----------------------------------------------------------------------------
package tvlg_pkg;

  localparam int GRAD_W   = 32;
  localparam int LOSS_W   = 48;
  localparam int STR_W    = 16;
  localparam int EPS_W    = 32;
  localparam int LEN_W    = 11;
  localparam int ROW_W    = 20;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int RAD_W    = 64;
  localparam int ROOT_W   = 32;
  localparam int REM_W    = 36;
  localparam int CNT_W    = 5;
  localparam int SUM_W    = 40;
  localparam int Q_W      = 16;
  localparam int TERM_W   = 24;
  localparam int PROD_W   = 66;
  localparam int L2_SHIFT = 13;
  localparam int LOSS_SHIFT = 6;
  // quotient magnitude never exceeds one in Q.14, so 15 bits suffice
  localparam logic [CNT_W-1:0] ROOT_LAST = 5'd31;
  localparam logic [CNT_W-1:0] DIV_LAST  = 5'd14;

  localparam logic [STR_W-1:0] STRENGTH_RST = 16'd256;
  localparam logic [EPS_W-1:0] EPSILON_RST  = 32'd3;
  localparam logic [LEN_W-1:0] LENGTH_RST   = 11'd1024;

  // input transaction kinds
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STRENGTH    = 2'd0,
    CFG_EPSILON     = 2'd1,
    CFG_LINE_LENGTH = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    OP_ROOT = 1'b0,
    OP_DIV  = 1'b1
  } iter_op_t;

  typedef struct packed {
    logic     start;
    iter_op_t op;
  } iter_req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_L2,
    ST_RDA,
    ST_RDB,
    ST_SQX,
    ST_SQY,
    ST_RAD,
    ST_SQ_GO,
    ST_SQ_WAIT,
    ST_DX_GO,
    ST_DX_WAIT,
    ST_DY_GO,
    ST_DY_WAIT,
    ST_MSX,
    ST_MSY,
    ST_MSD,
    ST_WB0,
    ST_WB1,
    ST_WB2,
    ST_DR0,
    ST_DR1,
    ST_OUT
  } state_t;

  // clamp a wide signed sum to the 32 bit gradient range
  function automatic logic signed [GRAD_W-1:0] sat_grad(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(64'sh7FFF_FFFF);
    lo = -SUM_W'(64'sh8000_0000);
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[GRAD_W-1:0];
  endfunction

  // clamp an unsigned value to 48 bits
  function automatic logic [LOSS_W-1:0] sat_loss(input logic [63:0] v);
    if (|v[63:LOSS_W]) begin
      return '1;
    end
    return v[LOSS_W-1:0];
  endfunction

endpackage

// ===== src/tvlg_ram.sv =====
// ----------------------------------------------------------------------------
// tvlg_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tvlg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/tvlg_root_div.sv =====
// ----------------------------------------------------------------------------
// tvlg_root_div
// Shared iterative unit: 64 bit integer square root (one result bit per
// cycle) and restoring division of magnitude * 2^14 by a 32 bit divisor.
// ----------------------------------------------------------------------------
module tvlg_root_div
  import tvlg_pkg::*;
#(
  parameter int NUM_W = 17
) (
  input  logic              clk,
  input  logic              rst,
  input  iter_req_t         req,
  input  logic [RAD_W-1:0]  radicand,
  input  logic [NUM_W-1:0]  numer,
  input  logic [ROOT_W-1:0] denom,
  output logic              done,
  output logic [ROOT_W-1:0] result
);

  logic              busy;
  iter_op_t          op_r;
  logic [CNT_W-1:0]  cnt;
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] acc;
  logic [RAD_W-1:0]  src;
  logic [ROOT_W-1:0] den_r;

  logic [REM_W-1:0]  shifted;
  logic [REM_W-1:0]  operand;
  logic [REM_W-1:0]  diff;
  logic              fits;

  // one compare and subtract shared by both operations
  always_comb begin
    if (op_r == OP_ROOT) begin
      shifted = {rem[REM_W-3:0], src[RAD_W-1:RAD_W-2]};
      operand = {2'b00, acc, 2'b01};
    end else begin
      shifted = {rem[REM_W-2:0], src[RAD_W-1]};
      operand = REM_W'(den_r);
    end
    fits = shifted >= operand;
    diff = shifted - operand;
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      op_r <= OP_ROOT;
    end else begin
      done <= busy && (cnt == '0);
      if (req.start) begin
        busy <= 1'b1;
        op_r <= req.op;
        cnt  <= (req.op == OP_ROOT) ? ROOT_LAST : DIV_LAST;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      acc   <= '0;
      den_r <= denom;
      if (req.op == OP_ROOT) begin
        rem <= '0;
        src <= radicand;
      end else begin
        rem <= REM_W'(numer >> 1);
        src <= {numer[0], {(RAD_W-1){1'b0}}};
      end
    end else if (busy) begin
      rem <= fits ? diff : shifted;
      acc <= {acc[ROOT_W-2:0], fits};
      src <= (op_r == OP_ROOT) ? (src << 2) : (src << 1);
    end
  end

  assign result = acc;

endmodule

// ===== src/tv_l2_loss_gradient_top.sv =====
// ----------------------------------------------------------------------------
// tv_l2_loss_gradient_top
// Streaming total variation plus L2 loss gradient over a raster image.
// ----------------------------------------------------------------------------
// A pixel with right and lower neighbours uses the shared unit for a root
// (32 root steps) and two 15 step divisions; the divisions are skipped when
// the root is zero. Other pixels and drain transactions skip the unit.
// One transaction at a time: a new one is accepted only once the last is
// through, and later while a result waits in the output.
// Reset (synchronous, active high) clears counters and sums, restores defaults.
module tv_l2_loss_gradient_top
  import tvlg_pkg::*;
#(
  parameter int MAX_COLS    = 1024,
  parameter int PIXEL_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          cmd,
  input  logic signed [PIXEL_WIDTH-1:0] estimate,
  input  logic signed [PIXEL_WIDTH-1:0] reference,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [GRAD_W-1:0]      gradient,
  output logic [LOSS_W-1:0]             loss,
  output logic                          final_res,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data
);

  localparam int PW = PIXEL_WIDTH;
  localparam int CW = $clog2(MAX_COLS);
  localparam int PA = $clog2(2 * MAX_COLS);
  localparam int LW = (CW + 2 > 12) ? CW + 2 : 12;
  localparam int MW = (PW + 1 > 17) ? PW + 1 : 17;

  // configuration
  logic [STR_W-1:0] strength;
  logic [EPS_W-1:0] epsilon;
  logic [LEN_W-1:0] line_length;

  // frame state
  logic [CW-1:0]          column_position;
  logic [ROW_W-1:0]       row_position;
  logic [CW-1:0]          drain_position;
  logic [LOSS_W-1:0]      tv_sum;
  logic [LOSS_W-1:0]      l2_sum;
  logic signed [PW-1:0]   previous_pixel;

  state_t state, state_next;

  // per transaction registers
  logic signed [PW-1:0]     est_r;
  logic signed [PW-1:0]     ref_r;
  logic signed [PW-1:0]     a_r;
  logic signed [PW-1:0]     b_r;
  logic signed [GRAD_W-1:0] p0;
  logic signed [GRAD_W-1:0] p1;
  logic [RAD_W-1:0]         sqx;
  logic [RAD_W-1:0]         rad;
  logic [ROOT_W-1:0]        mag;
  logic signed [Q_W-1:0]    qx;
  logic signed [Q_W-1:0]    qy;
  logic signed [TERM_W-1:0] sx;
  logic signed [TERM_W-1:0] sy;
  logic signed [GRAD_W-1:0] grad_hold;
  logic [LOSS_W-1:0]        loss_hold;
  logic                     final_hold;
  logic signed [PROD_W-1:0] mul_q;
  logic [63:0]              loss_prod;

  // derived values
  logic [LW-1:0]            len_ext;
  logic [CW-1:0]            last_col;
  logic signed [PW:0]       diff;
  logic signed [PW:0]       dx;
  logic signed [PW:0]       dy;
  logic [PW:0]              dx_mag;
  logic [PW:0]              dy_mag;
  logic signed [MW-1:0]     mul_a;
  logic signed [MW-1:0]     mul_b;
  logic signed [MW-1:0]     str_s;
  logic [PA-1:0]            cur_base;
  logic [PA-1:0]            prv_base;
  logic [PA-1:0]            drn_base;
  logic [PROD_W-1:0]        rad_sum;
  logic signed [GRAD_W-1:0] upd0;
  logic signed [GRAD_W-1:0] upd1;
  logic signed [GRAD_W-1:0] fresh;
  logic [Q_W-2:0]           qmag;
  logic                     has_row;
  logic                     in_row;

  // memory ports
  logic             rp_we;
  logic [CW-1:0]    rp_waddr;
  logic [CW-1:0]    rp_raddr;
  logic [PW-1:0]    rp_q;
  logic             pg_we;
  logic [PA-1:0]    pg_waddr;
  logic [GRAD_W-1:0] pg_wdata;
  logic [PA-1:0]    pg_raddr;
  logic [GRAD_W-1:0] pg_q;

  // iterative unit
  iter_req_t         req;
  logic              unit_done;
  logic [ROOT_W-1:0] unit_res;
  logic [PW:0]       unit_num;

  // effective last column of a row, clamped to 2..MAX_COLS pixels
  always_comb begin
    len_ext = LW'(line_length);
    if (len_ext < LW'(2)) begin
      last_col = CW'(1);
    end else if (len_ext > LW'(MAX_COLS)) begin
      last_col = CW'(MAX_COLS - 1);
    end else begin
      last_col = CW'(len_ext - LW'(1));
    end
  end

  // differences and saturated updates
  always_comb begin
    diff     = (PW+1)'(est_r) - (PW+1)'(ref_r);
    dx       = (PW+1)'(a_r) - (PW+1)'(b_r);
    dy       = (PW+1)'(a_r) - (PW+1)'(est_r);
    dx_mag   = dx[PW] ? (PW+1)'(-dx) : dx;
    dy_mag   = dy[PW] ? (PW+1)'(-dy) : dy;
    str_s    = MW'($signed({1'b0, strength}));
    cur_base = row_position[0] ? PA'(MAX_COLS) : '0;
    prv_base = row_position[0] ? '0 : PA'(MAX_COLS);
    drn_base = row_position[0] ? '0 : PA'(MAX_COLS);
    rad_sum  = PROD_W'(sqx) + PROD_W'(mul_q[RAD_W-1:0]) + PROD_W'(epsilon);
    upd0     = sat_grad(SUM_W'(p0) + SUM_W'(sx) + SUM_W'(sy));
    upd1     = sat_grad(SUM_W'(p1) - SUM_W'(sx));
    fresh    = sat_grad(SUM_W'(diff) - SUM_W'(sy));
    qmag     = unit_res[Q_W-2:0];
    has_row  = row_position != '0;
    in_row   = column_position < last_col;
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_L2: begin
        mul_a = MW'(diff);
        mul_b = MW'(diff);
      end
      ST_SQX: begin
        mul_a = MW'(dx);
        mul_b = MW'(dx);
      end
      ST_SQY: begin
        mul_a = MW'(dy);
        mul_b = MW'(dy);
      end
      ST_MSX: begin
        mul_a = str_s;
        mul_b = MW'(qx);
      end
      ST_MSY: begin
        mul_a = str_s;
        mul_b = MW'(qy);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_q     <= PROD_W'(mul_a * mul_b);
    loss_prod <= 64'(strength) * 64'(tv_sum);
  end

  // next state and memory / unit control
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    req        = '{start: 1'b0, op: OP_ROOT};
    unit_num   = dx_mag;
    rp_raddr   = column_position;
    pg_raddr   = prv_base + PA'(column_position);
    rp_we      = 1'b0;
    rp_waddr   = column_position;
    pg_we      = 1'b0;
    pg_waddr   = prv_base + PA'(column_position);
    pg_wdata   = upd0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = (cmd == CMD_DRAIN) ? ST_DR0 : ST_L2;
        end
      end
      ST_L2: state_next = ST_RDA;
      ST_RDA: begin
        rp_raddr   = column_position + CW'(1);
        pg_raddr   = prv_base + PA'(column_position) + PA'(1);
        state_next = (has_row && in_row) ? ST_RDB : ST_WB2;
      end
      ST_RDB:  state_next = ST_SQX;
      ST_SQX:  state_next = ST_SQY;
      ST_SQY:  state_next = ST_RAD;
      ST_RAD:  state_next = ST_SQ_GO;
      ST_SQ_GO: begin
        req        = '{start: 1'b1, op: OP_ROOT};
        state_next = ST_SQ_WAIT;
      end
      ST_SQ_WAIT: begin
        if (unit_done) begin
          state_next = (unit_res == '0) ? ST_MSX : ST_DX_GO;
        end
      end
      ST_DX_GO: begin
        req        = '{start: 1'b1, op: OP_DIV};
        state_next = ST_DX_WAIT;
      end
      ST_DX_WAIT: begin
        if (unit_done) begin
          state_next = ST_DY_GO;
        end
      end
      ST_DY_GO: begin
        req        = '{start: 1'b1, op: OP_DIV};
        unit_num   = dy_mag;
        state_next = ST_DY_WAIT;
      end
      ST_DY_WAIT: begin
        if (unit_done) begin
          state_next = ST_MSX;
        end
      end
      ST_MSX: state_next = ST_MSY;
      ST_MSY: state_next = ST_MSD;
      ST_MSD: state_next = ST_WB0;
      ST_WB0: begin
        pg_we      = 1'b1;
        state_next = ST_WB1;
      end
      ST_WB1: begin
        pg_we      = 1'b1;
        pg_waddr   = prv_base + PA'(column_position) + PA'(1);
        pg_wdata   = upd1;
        state_next = ST_WB2;
      end
      ST_WB2: begin
        pg_we      = 1'b1;
        pg_waddr   = cur_base + PA'(column_position);
        pg_wdata   = fresh;
        rp_we      = 1'b1;
        state_next = has_row ? ST_OUT : ST_IDLE;
      end
      ST_DR0: begin
        pg_raddr   = drn_base + PA'(drain_position);
        state_next = (has_row && column_position == '0) ? ST_DR1 : ST_IDLE;
      end
      ST_DR1: state_next = ST_OUT;
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      strength    <= STRENGTH_RST;
      epsilon     <= EPSILON_RST;
      line_length <= LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STRENGTH:    strength    <= cfg_data[STR_W-1:0];
        CFG_EPSILON:     epsilon     <= cfg_data[EPS_W-1:0];
        CFG_LINE_LENGTH: line_length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // frame counters and sums
  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position    <= '0;
      drain_position  <= '0;
      tv_sum          <= '0;
      l2_sum          <= '0;
      previous_pixel  <= '0;
    end else begin
      case (state)
        ST_RDA: l2_sum <= sat_loss(64'(l2_sum) + (mul_q[RAD_W-1:0] >> L2_SHIFT));
        ST_SQ_WAIT: begin
          if (unit_done) begin
            tv_sum <= sat_loss(64'(tv_sum) + 64'(unit_res));
          end
        end
        ST_WB2: begin
          drain_position <= '0;
          previous_pixel <= est_r;
          if (column_position >= last_col) begin
            column_position <= '0;
            if (row_position != '1) begin
              row_position <= row_position + 1'b1;
            end
          end else begin
            column_position <= column_position + 1'b1;
          end
        end
        ST_DR1: begin
          if (drain_position >= last_col) begin
            column_position <= '0;
            row_position    <= '0;
            drain_position  <= '0;
            tv_sum          <= '0;
            l2_sum          <= '0;
          end else begin
            drain_position <= drain_position + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // per transaction datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          est_r <= estimate;
          ref_r <= reference;
        end
      end
      ST_L2: begin
        sx <= '0;
        sy <= '0;
      end
      ST_RDA: begin
        a_r       <= $signed(rp_q);
        p0        <= $signed(pg_q);
        grad_hold <= $signed(pg_q);
      end
      ST_RDB: begin
        b_r <= $signed(rp_q);
        p1  <= $signed(pg_q);
      end
      ST_SQY: sqx <= mul_q[RAD_W-1:0];
      ST_RAD: rad <= (|rad_sum[PROD_W-1:RAD_W]) ? '1 : rad_sum[RAD_W-1:0];
      ST_SQ_WAIT: begin
        if (unit_done) begin
          mag <= unit_res;
          qx  <= '0;
          qy  <= '0;
        end
      end
      ST_DX_WAIT: begin
        if (unit_done) begin
          qx <= dx[PW] ? -Q_W'(qmag) : Q_W'(qmag);
        end
      end
      ST_DY_WAIT: begin
        if (unit_done) begin
          qy <= dy[PW] ? -Q_W'(qmag) : Q_W'(qmag);
        end
      end
      ST_MSY: sx <= mul_q[31:8];
      ST_MSD: sy <= mul_q[31:8];
      ST_WB0: grad_hold <= upd0;
      ST_WB2: begin
        loss_hold  <= '0;
        final_hold <= 1'b0;
      end
      ST_DR1: begin
        grad_hold <= $signed(pg_q);
        if (drain_position >= last_col) begin
          loss_hold  <= sat_loss(64'(sat_loss(loss_prod >> LOSS_SHIFT)) + 64'(l2_sum));
          final_hold <= 1'b1;
        end else begin
          loss_hold  <= '0;
          final_hold <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!out_valid || out_ready)) begin
      gradient  <= grad_hold;
      loss      <= loss_hold;
      final_res <= final_hold;
    end
  end

  // previous row estimates
  tvlg_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_COLS)
  ) u_row_pixels (
    .clk   (clk),
    .we    (rp_we),
    .waddr (rp_waddr),
    .wdata (est_r),
    .raddr (rp_raddr),
    .rdata (rp_q)
  );

  // partial gradients of two rows
  tvlg_ram #(
    .WIDTH (GRAD_W),
    .DEPTH (2 * MAX_COLS)
  ) u_partial_gradients (
    .clk   (clk),
    .we    (pg_we),
    .waddr (pg_waddr),
    .wdata (pg_wdata),
    .raddr (pg_raddr),
    .rdata (pg_q)
  );

  // shared root and divide unit
  tvlg_root_div #(
    .NUM_W (PW + 1)
  ) u_root_div (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .radicand (rad),
    .numer    (unit_num),
    .denom    (mag),
    .done     (unit_done),
    .result   (unit_res)
  );

endmodule

// ===== verif/tv_l2_loss_gradient_top_test.sv =====
// ----------------------------------------------------------------------------
// tv_l2_loss_gradient_top_test
// Self-checking bench for the tv/l2 loss gradient block: raster frames of
// random and extreme pixels with drain transactions are streamed in, a
// predictor works out every gradient and the frame loss, and the scoreboard
// compares each result transaction field by field.
// ----------------------------------------------------------------------------
module tv_l2_loss_gradient_top_test;
  import tvlg_pkg::*;

  localparam int MAX_COLS    = 1024;
  localparam int PIXEL_WIDTH = 16;
  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE      = 100;
  localparam int HOLD_OFF    = 400;
  localparam longint unsigned LIM48 = 64'hFFFF_FFFF_FFFF;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  logic                          cmd;
  logic signed [PIXEL_WIDTH-1:0] estimate;
  logic signed [PIXEL_WIDTH-1:0] reference;
  logic                          out_valid;
  logic                          out_ready;
  logic signed [GRAD_W-1:0]      gradient;
  logic [LOSS_W-1:0]             loss;
  logic                          final_res;
  logic                          cfg_we;
  logic [CFG_IDX_W-1:0]          cfg_index;
  logic [CFG_W-1:0]              cfg_data;

  typedef struct {
    logic signed [GRAD_W-1:0] grad;
    logic [LOSS_W-1:0]        total;
    logic                     last;
  } grad_result_t;

  // gradient predictor and result store
  class loss_gradient_board;
    int                 row_est[MAX_COLS];
    int                 part_grad[2*MAX_COLS];
    int unsigned        col_pos;
    int unsigned        row_pos;
    int unsigned        drain_pos;
    longint unsigned    tv_acc;
    longint unsigned    l2_acc;
    int unsigned        weight;
    longint unsigned    eps;
    int unsigned        length;
    grad_result_t       pending_grads[$];
    int                 n_errors;
    int                 n_grads;
    int                 n_frames;

    function void restart();
      col_pos = 0;
      row_pos = 0;
      drain_pos = 0;
      tv_acc = 0;
      l2_acc = 0;
      weight = STRENGTH_RST;
      eps = EPSILON_RST;
      length = LENGTH_RST;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_W-1:0] v);
      case (idx)
        CFG_STRENGTH:    weight = v[STR_W-1:0];
        CFG_EPSILON:     eps = v[EPS_W-1:0];
        CFG_LINE_LENGTH: length = v[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function longint unsigned sat48(longint unsigned v);
      return (v > LIM48) ? LIM48 : v;
    endfunction

    function int sat32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return int'(v);
    endfunction

    function longint unsigned sq(longint d);
      longint unsigned a;
      a = (d < 0) ? longint'(-d) : d;
      return a * a;
    endfunction

    function longint unsigned add_sat(longint unsigned a, longint unsigned b);
      longint unsigned s;
      s = a + b;
      return (s < a) ? 64'hFFFF_FFFF_FFFF_FFFF : s;
    endfunction

    // bitwise integer square root
    function longint unsigned root(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function int unsigned eff_len();
      if (length < 2) return 2;
      if (length > MAX_COLS) return MAX_COLS;
      return length;
    endfunction

    // note an accepted transaction and queue what it causes
    function void take_item(logic c, logic signed [PIXEL_WIDTH-1:0] e,
                            logic signed [PIXEL_WIDTH-1:0] r);
      int unsigned     last;
      int unsigned     col;
      int unsigned     cur;
      int unsigned     prv;
      int unsigned     base;
      longint          est;
      longint          fresh;
      longint          a;
      longint          dx;
      longint          dy;
      longint          qx;
      longint          qy;
      longint          sx;
      longint          sy;
      longint unsigned mag;
      grad_result_t    res;
      last = eff_len() - 1;
      res.total = '0;
      res.last = 1'b0;
      if (c == CMD_PIXEL) begin
        est = e;
        fresh = est - longint'(r);
        col = (col_pos < MAX_COLS) ? col_pos : MAX_COLS - 1;
        cur = row_pos[0] ? MAX_COLS : 0;
        prv = MAX_COLS - cur;
        drain_pos = 0;
        l2_acc = sat48(l2_acc + (sq(fresh) >> L2_SHIFT));
        if (row_pos > 0) begin
          if (col < last) begin
            a = row_est[col];
            dx = a - row_est[col+1];
            dy = a - est;
            mag = root(add_sat(add_sat(sq(dx), sq(dy)), eps));
            tv_acc = sat48(tv_acc + mag);
            qx = 0;
            qy = 0;
            if (mag != 0) begin
              qx = (dx * 16384) / longint'(mag);
              qy = (dy * 16384) / longint'(mag);
            end
            sx = (longint'(weight) * qx) >>> 8;
            sy = (longint'(weight) * qy) >>> 8;
            part_grad[prv+col] = sat32(longint'(part_grad[prv+col]) + sx + sy);
            part_grad[prv+col+1] = sat32(longint'(part_grad[prv+col+1]) - sx);
            fresh = fresh - sy;
          end
          res.grad = part_grad[prv+col];
          pending_grads.push_back(res);
        end
        part_grad[cur+col] = sat32(fresh);
        row_est[col] = int'(est);
        if (col >= last) begin
          col_pos = 0;
          if (row_pos < 20'hFFFFF) row_pos++;
        end else begin
          col_pos = col + 1;
        end
        return;
      end
      // drain: only on a row boundary with a complete row behind it
      if (row_pos == 0 || col_pos != 0) return;
      base = ((row_pos - 1) & 1) ? MAX_COLS : 0;
      col = (drain_pos < MAX_COLS) ? drain_pos : MAX_COLS - 1;
      res.grad = part_grad[base+col];
      if (col >= last) begin
        res.total = sat48(sat48((64'(weight) * tv_acc) >> LOSS_SHIFT) + l2_acc);
        res.last = 1'b1;
        col_pos = 0;
        row_pos = 0;
        drain_pos = 0;
        tv_acc = 0;
        l2_acc = 0;
      end else begin
        drain_pos = col + 1;
      end
      pending_grads.push_back(res);
    endfunction

    function void match_result(logic signed [GRAD_W-1:0] g, logic [LOSS_W-1:0] l, logic f);
      grad_result_t exp_res;
      if (pending_grads.size() == 0) begin
        $error("unexpected result: gradient %0d", g);
        n_errors++;
        return;
      end
      exp_res = pending_grads.pop_front();
      n_grads++;
      if (exp_res.last) n_frames++;
      if (g !== exp_res.grad) begin
        $error("gradient: expected %0d, got %0d", exp_res.grad, g);
        n_errors++;
      end
      if (l !== exp_res.total) begin
        $error("loss: expected %0d, got %0d", exp_res.total, l);
        n_errors++;
      end
      if (f !== exp_res.last) begin
        $error("final_res: expected %0d, got %0d", exp_res.last, f);
        n_errors++;
      end
    endfunction
  endclass

  loss_gradient_board board;
  bit quiet_phase;
  int hold_cycles;
  int items_sent;
  int stall_count;

  tv_l2_loss_gradient_top #(
    .MAX_COLS    (MAX_COLS),
    .PIXEL_WIDTH (PIXEL_WIDTH)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .estimate  (estimate),
    .reference (reference),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .gradient  (gradient),
    .loss      (loss),
    .final_res (final_res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function bit idle_now();
    return !quiet_phase && ($urandom_range(99) < 36);
  endfunction

  // result side: random back-pressure plus one long hold-off
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        board.match_result(gradient, loss, final_res);
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !idle_now();
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  task automatic send(logic c, logic signed [PIXEL_WIDTH-1:0] e,
                      logic signed [PIXEL_WIDTH-1:0] r);
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= c;
    estimate  <= e;
    reference <= r;
    do @(posedge clk); while (!in_ready);
    board.take_item(c, e, r);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.pending_grads.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    board.write_reg(idx, v);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function logic signed [PIXEL_WIDTH-1:0] pick_pixel();
    case ($urandom_range(7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return PIXEL_WIDTH'($urandom);
    endcase
  endfunction

  task automatic send_row(int len);
    for (int c = 0; c < len; c++) begin
      // drain in the middle of a row is ignored
      if (c > 0 && $urandom_range(19) == 0) send(CMD_DRAIN, pick_pixel(), pick_pixel());
      send(CMD_PIXEL, pick_pixel(), pick_pixel());
    end
  endtask

  // one frame of well-formed rows, with occasional early and broken drains
  task automatic send_frame(int rows);
    int len;
    int k;
    len = board.eff_len();
    if ($urandom_range(9) == 0) send(CMD_DRAIN, pick_pixel(), pick_pixel());
    for (int r = 0; r < rows; r++) send_row(len);
    k = ($urandom_range(7) == 0) ? $urandom_range(1, len - 1) : len;
    for (int d = 0; d < k; d++) send(CMD_DRAIN, pick_pixel(), pick_pixel());
    if (k < len) begin
      // a pixel row cuts the drain short, so the frame carries on
      send_row(len);
      for (int d = 0; d < len; d++) send(CMD_DRAIN, pick_pixel(), pick_pixel());
    end
  endtask

  initial begin
    int phase;
    board = new();
    board.restart();
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = CMD_PIXEL;
    estimate = '0;
    reference = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_STRENGTH;
    cfg_data = '0;
    quiet_phase = 1'b0;
    hold_cycles = 0;
    items_sent = 0;
    board.n_errors = 0;
    board.n_grads = 0;
    board.n_frames = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extreme weight, zero epsilon, line length below range
    write_reg(CFG_STRENGTH, 32'h0000_FFFF);
    write_reg(CFG_EPSILON, 32'h0);
    write_reg(CFG_LINE_LENGTH, 32'h0);
    send(CMD_DRAIN, 16'sh0, 16'sh0);           // drain with no complete row
    send(CMD_PIXEL, 16'sh7FFF, 16'sh8000);
    send(CMD_PIXEL, 16'sh8000, 16'sh7FFF);
    send(CMD_PIXEL, 16'sh7FFF, 16'sh7FFF);
    send(CMD_DRAIN, 16'sh7FFF, 16'sh7FFF);     // mid-row drain
    send(CMD_PIXEL, 16'sh8000, 16'sh0);
    send(CMD_DRAIN, 16'sh0, 16'sh0);
    send(CMD_PIXEL, 16'sh0, 16'sh0);           // pixel during drain
    send(CMD_PIXEL, 16'sh0, 16'sh0);
    send(CMD_DRAIN, 16'sh0, 16'sh0);
    send(CMD_DRAIN, 16'sh0, 16'sh0);
    // flat image with zero epsilon: root of zero
    for (int i = 0; i < 4; i++) send(CMD_PIXEL, 16'sh1234, 16'sh1234);
    for (int i = 0; i < 2; i++) send(CMD_DRAIN, 16'sh0, 16'sh0);
    wait_drained();
    write_reg(CFG_STRENGTH, 32'h0);
    write_reg(CFG_EPSILON, 32'hFFFF_FFFF);
    write_reg(CFG_LINE_LENGTH, 32'h1);
    for (int i = 0; i < 4; i++) send(CMD_PIXEL, 16'sh8000, 16'sh7FFF);
    for (int i = 0; i < 2; i++) send(CMD_DRAIN, 16'sh0, 16'sh0);
    wait_drained();

    // random frames on small lines
    phase = 0;
    while (items_sent < 780) begin
      if ($urandom_range(1)) begin
        case ($urandom_range(3))
          0: write_reg(CFG_STRENGTH, 32'h0);
          1: write_reg(CFG_STRENGTH, 32'hFFFF);
          default: write_reg(CFG_STRENGTH, $urandom);
        endcase
      end
      if ($urandom_range(1)) begin
        case ($urandom_range(3))
          0: write_reg(CFG_EPSILON, 32'h0);
          1: write_reg(CFG_EPSILON, 32'hFFFF_FFFF);
          2: write_reg(CFG_EPSILON, $urandom_range(255));
          default: write_reg(CFG_EPSILON, $urandom);
        endcase
      end
      write_reg(CFG_LINE_LENGTH, $urandom_range(0, 9));
      quiet_phase = (phase == 4 || phase == 5);
      if (phase == 2) hold_cycles = HOLD_OFF;
      send_frame($urandom_range(1, 4));
      wait_drained();
      phase++;
    end
    quiet_phase = 1'b0;

    $display("covered %0d input transactions, %0d gradients, %0d frames in %0d phases",
             items_sent, board.n_grads, board.n_frames, phase + 2);
    if (board.n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
